// ===== rtl/core/set_assoc_lru_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
// No dependencies; included inside module bodies.
`ifndef SET_ASSOC_LRU_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define SALC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the next cycle, outside reset.
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/salc_pkg.sv =====
// Package for the set-associative LRU cache: sizes and beat types.
// No dependencies.
package salc_pkg;
  localparam int NUM_SETS  = 4;
  localparam int WAYS      = 4;
  localparam int ADDR_BITS = 16;
  localparam int DATA_BITS = 32;

  localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS + 1) - 1 : 0;
  localparam int IDX_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W    = WAY_W;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_ADD    = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  set_index;
    logic        evicted;
    logic [15:0] evicted_address;
    logic [31:0] read_value;
  } rsp_t;
endpackage

// ===== rtl/core/set_assoc_lru_cache.sv =====
// Set-associative cache with true LRU replacement, top level.
// Depends on salc_pkg and set_assoc_lru_cache_defines.svh.
//
// Use: present a request beat on in_valid/in_data (kind, address, write_value).
// kind KIND_LOOKUP reads and touches a line; KIND_ADD writes or allocates one.
// Every accepted beat gives exactly one result beat on out_valid/out_data.
// The line store sits in one synchronous memory per field (one row per set,
// all ways side by side), read into a register.
// Flow: the row is read at the accept edge; the next cycle compares all ways,
// builds the result and writes back the row. out_valid rises at the edge that
// ends the compare cycle, unless the output register is still full.
// The read-modify-write of a set row must finish before the next request
// reads the memory, so no request is accepted until the compare cycle is done.
// The result sits in an output register; the next request is accepted while
// it waits, and its result is held back until the register drains.
// Reset: all valid bits clear at once (flip-flops); tags and data need no
// clearing. Ranks live with the valid bits and are cleared too.
// Stall: a blocked out_ready holds the result and stops further accepts once
// a second result is ready.
module set_assoc_lru_cache (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  salc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output salc_pkg::rsp_t out_data
);
  import salc_pkg::*;
  `include "set_assoc_lru_cache_defines.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_WAIT} state_t;

  // row memories: tag and data, one row per set
  logic [WAYS-1:0][TAG_BITS-1:0]  tag_mem  [NUM_SETS];
  logic [WAYS-1:0][DATA_BITS-1:0] data_mem [NUM_SETS];
  logic [WAYS-1:0][TAG_BITS-1:0]  tag_rd_r;
  logic [WAYS-1:0][DATA_BITS-1:0] data_rd_r;

  // valid bits and ranks in flip-flops
  logic [WAYS-1:0]             valid_r [NUM_SETS];
  logic [WAYS-1:0][RANK_W-1:0] rank_r  [NUM_SETS];

  state_t state_r;
  req_t   req_r;
  rsp_t   out_r, out_nxt;
  logic   out_valid_r;

  logic [IDX_W-1:0]    set_in, set_r;
  logic [TAG_BITS-1:0] tag_r;

  assign set_in = (SET_BITS > 0) ? IDX_W'(in_data.address) : '0;
  assign set_r  = (SET_BITS > 0) ? IDX_W'(req_r.address) : '0;
  assign tag_r  = TAG_BITS'(req_r.address[ADDR_BITS-1:SET_BITS]);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // compare stage
  logic [WAYS-1:0]             vrow;
  logic [WAYS-1:0][RANK_W-1:0] rrow, rrow_nxt;
  logic                        hit, has_free, do_write, do_alloc;
  logic [WAY_W-1:0]            hit_way, free_way, old_way, tgt_way;
  logic [RANK_W-1:0]           old_rank, cut_rank;
  logic                        cut_all;

  always_comb begin
    vrow = valid_r[set_r];
    rrow = rank_r[set_r];
    hit = 1'b0; hit_way = '0;
    has_free = 1'b0; free_way = '0;
    old_way = '0; old_rank = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow[w] && tag_rd_r[w] == tag_r) begin
        hit = 1'b1; hit_way = WAY_W'(w);
      end
      if (!vrow[w]) begin
        has_free = 1'b1; free_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (rrow[w] >= old_rank) begin
        old_rank = rrow[w]; old_way = WAY_W'(w);
      end
    end
    do_alloc = !hit && req_r.kind == KIND_ADD;
    do_write = req_r.kind == KIND_ADD;
    tgt_way  = hit ? hit_way : (has_free ? free_way : old_way);
    cut_all  = do_alloc && has_free;
    cut_rank = hit ? rrow[hit_way] : old_rank;
    rrow_nxt = rrow;
    if (hit || do_alloc) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WAY_W'(w) != tgt_way && vrow[w] && (cut_all || rrow[w] < cut_rank))
          rrow_nxt[w] = rrow[w] + RANK_W'(1);
      end
      rrow_nxt[tgt_way] = '0;
    end
    out_nxt = '0;
    out_nxt.hit = hit;
    out_nxt.set_index = 2'(set_r);
    if (hit) out_nxt.read_value = 32'(data_rd_r[hit_way]);
    if (do_alloc && !has_free) begin
      out_nxt.evicted = 1'b1;
      out_nxt.evicted_address = 16'({tag_rd_r[old_way], set_r});
    end
  end

  // memories: read on accept, write back in the compare cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tag_rd_r  <= tag_mem[set_in];
      data_rd_r <= data_mem[set_in];
    end
    if (state_r == ST_LOOK && do_write) begin
      data_mem[set_r][tgt_way] <= DATA_BITS'(req_r.write_value);
      if (do_alloc) tag_mem[set_r][tgt_way] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (state_r == ST_LOOK && !(out_valid_r && !out_ready)) out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
        rank_r[s]  <= '0;
      end
    end else begin
      // drop the result once taken; the compare cycle reloads it instead
      if (state_r != ST_LOOK && out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_valid) state_r <= ST_LOOK;
        ST_LOOK: begin
          // hold the result when the output register is still full
          if (out_valid_r && !out_ready) begin
            state_r <= ST_WAIT;
          end else begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            rank_r[set_r] <= rrow_nxt;
            if (do_alloc) valid_r[set_r][tgt_way] <= 1'b1;
          end
        end
        ST_WAIT: state_r <= ST_LOOK;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SALC_ASSERT(a_one_rank_zero, !(state_r == ST_LOOK && hit) || (rrow_nxt[hit_way] == '0), "hit line not made MRU")
  `SALC_ASSERT_NEXT(a_look_after_accept, in_valid && in_ready, state_r == ST_LOOK, "accept did not start lookup")
  `SALC_ASSERT(a_no_accept_busy, !(in_ready && state_r != ST_IDLE), "accept while busy")
endmodule

// ===== bench/tb_set_assoc_lru_cache.sv =====
// Testbench for set_assoc_lru_cache: random and directed request beats, checked
// against a built-in LRU cache predictor. Depends on salc_pkg and the cache RTL.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache;
  import salc_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  // Scoreboard: predicts each result from its request and keeps a queue of
  // expected result beats.
  class cache_scoreboard;
    logic               valid_q [NUM_SETS][WAYS];
    logic [TAG_BITS-1:0] tag_q  [NUM_SETS][WAYS];
    logic [31:0]        data_q  [NUM_SETS][WAYS];
    int unsigned        rank_q  [NUM_SETS][WAYS];
    rsp_t               pending [$];
    int                 errors;

    function new();
      errors = 0;
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < WAYS; w++) begin
          valid_q[s][w] = 1'b0; tag_q[s][w] = '0; data_q[s][w] = '0; rank_q[s][w] = 0;
        end
    endfunction

    // Make a way MRU; valid lines newer than its old rank age by one.
    function void make_mru(int s, int way, int unsigned r);
      for (int w = 0; w < WAYS; w++)
        if (w != way && valid_q[s][w] && rank_q[s][w] < r) rank_q[s][w]++;
      rank_q[s][way] = 0;
    endfunction

    function void note_request(req_t rq);
      rsp_t        rs;
      int          s, hw, fw, way;
      int unsigned r;
      logic [TAG_BITS-1:0] tg;
      s  = int'(rq.address[SET_BITS-1:0]);
      tg = rq.address[ADDR_BITS-1:SET_BITS];
      hw = -1; fw = -1;
      rs = '0;
      rs.set_index = s[1:0];
      for (int w = 0; w < WAYS; w++) begin
        if (valid_q[s][w]) begin
          if (hw < 0 && tag_q[s][w] == tg) hw = w;
        end else if (fw < 0) fw = w;
      end
      if (hw >= 0) begin
        rs.hit = 1'b1;
        rs.read_value = data_q[s][hw];
        if (rq.kind == KIND_ADD) data_q[s][hw] = rq.write_value;
        make_mru(s, hw, rank_q[s][hw]);
      end else if (rq.kind == KIND_ADD) begin
        if (fw >= 0) begin
          way = fw;
          valid_q[s][way] = 1'b1;
          make_mru(s, way, WAYS + 1);
        end else begin
          way = 0; r = 0;
          for (int w = 0; w < WAYS; w++)
            if (rank_q[s][w] >= r) begin r = rank_q[s][w]; way = w; end
          rs.evicted = 1'b1;
          rs.evicted_address = {tag_q[s][way], rq.address[SET_BITS-1:0]};
          make_mru(s, way, r);
        end
        tag_q[s][way]  = tg;
        data_q[s][way] = rq.write_value;
      end
      pending.insert(pending.size(), rs);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task automatic check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 32'(got), 32'(0));
        return;
      end
      want = pending.pop_front();
      if (got.hit != want.hit) report("hit", 32'(got.hit), 32'(want.hit));
      if (got.set_index != want.set_index)
        report("set_index", 32'(got.set_index), 32'(want.set_index));
      if (got.evicted != want.evicted)
        report("evicted", 32'(got.evicted), 32'(want.evicted));
      if (got.evicted_address != want.evicted_address)
        report("evicted_address", 32'(got.evicted_address), 32'(want.evicted_address));
      if (got.read_value != want.read_value)
        report("read_value", got.read_value, want.read_value);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  req_t in_data;
  rsp_t out_data;

  set_assoc_lru_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  cache_scoreboard sb = new();
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;      // long receiver stall, set by the stimulus process
  int  idle_cycles = 0;

  // Receiver: drop ready at random, or for the whole hold-off stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each accepted result beat; count cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one beat and hold it until accepted; random gap before it.
  // Valid stays high after the accept; the next beat or drain() drops it.
  task automatic send_beat(logic kind, logic [15:0] addr, logic [31:0] value);
    req_t rq;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    rq.kind = kind; rq.address = addr; rq.write_value = value;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  // Mostly addresses from a small pool so sets hit, fill and evict.
  task automatic send_random();
    logic [15:0] addr;
    logic [31:0] value;
    logic        kind;
    value = $urandom;
    kind  = 1'($urandom_range(1));
    if ($urandom_range(9) < 8)
      addr = {11'($urandom_range(5)) ^ (($urandom_range(1) != 0) ? 11'h7ff : 11'h000),
              3'd0, 2'($urandom_range(3))};
    else addr = 16'($urandom);
    send_beat(kind, addr, value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lookup miss on empty cache, fill a set, add hit, eviction,
    // address extremes and data extremes.
    send_beat(KIND_LOOKUP, 16'h0000, 32'hffffffff);
    send_beat(KIND_ADD, 16'hffff, 32'hffffffff);
    send_beat(KIND_LOOKUP, 16'hffff, 32'h0);
    send_beat(KIND_ADD, 16'hffff, 32'h0);
    send_beat(KIND_LOOKUP, 16'hffff, 32'h0);
    for (int i = 0; i < 6; i++) send_beat(KIND_ADD, 16'(i << 2), 32'(i) * 32'h11111111);
    send_beat(KIND_LOOKUP, 16'h0008, 32'h0);
    send_beat(KIND_ADD, 16'h0100, 32'h12345678);
    send_beat(KIND_LOOKUP, 16'h0000, 32'h0);
    send_beat(KIND_LOOKUP, 16'h0100, 32'h0);
    send_beat(KIND_ADD, 16'hfffc, 32'h80000001);
    send_beat(KIND_LOOKUP, 16'hfffc, 32'h0);
    drain();

    send_idle_pct = 7; recv_idle_pct = 59;
    repeat (580) send_random();
    // Hold off the receiver while beats keep coming so the block backs up.
    hold_off = 1;
    fork
      begin repeat (200) @(posedge clk); hold_off = 0; end
      repeat (20) send_random();
    join
    send_idle_pct = 59; recv_idle_pct = 7;
    repeat (560) send_random();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (580) send_random();
    drain();

    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
